### rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared constants, types and codes of the banded sorted priority queue.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int ENTRIES_PER_BAND = 16;
    localparam int NUM_BANDS        = 3;
    localparam int CNT_W            = $clog2(ENTRIES_PER_BAND + 1);
    localparam int PRIO_W           = 6;
    localparam int TIME_W           = 16;
    localparam int BAND_W           = 2;
    localparam int STATUS_W         = 3;
    localparam int CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_ONE_TOP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_TWO_TOP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_THREE_TOP = 2'd2;

    localparam logic [PRIO_W-1:0] BAND_ONE_TOP_RST   = 6'd10;
    localparam logic [PRIO_W-1:0] BAND_TWO_TOP_RST   = 6'd20;
    localparam logic [PRIO_W-1:0] BAND_THREE_TOP_RST = 6'd30;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_NOTHING  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // Command broadcast to every cell of one band
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] job_time;
    } t_cell_cmd;

endpackage

### rtl/banded_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// banded_sorted_priority_queue
// Three-band sorted job queue built from shifting cell rows.
// ----------------------------------------------------------------------------
// The accept edge registers an item and picks its band; the update then shifts
// every cell of that band at once and loads the result register. No new item
// is taken until that update is done. The result register holds one finished
// item; while it waits to be taken one more item may be accepted, and its
// update waits until the result register frees. Cell storage needs no clearing
// after reset: the band counts say which cells hold jobs, so the block is ready
// on the first cycle out of reset.
module banded_sorted_priority_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsp_pkg::PRIO_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [bsp_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic [bsp_pkg::TIME_W-1:0]    i_job_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bsp_pkg::STATUS_W-1:0]  o_status,
    output logic [bsp_pkg::BAND_W-1:0]    o_band,
    output logic [bsp_pkg::PRIO_W-1:0]    o_out_priority,
    output logic [bsp_pkg::TIME_W-1:0]    o_out_time
);
    import bsp_pkg::*;

    logic [PRIO_W-1:0] r_top1, r_top2, r_top3;

    logic              r_busy;
    logic              r_act;
    logic              r_range;
    logic [BAND_W-1:0] r_band;
    logic [PRIO_W-1:0] r_prio;
    logic [TIME_W-1:0] r_time;

    logic              r_out_valid;
    t_status           r_status;
    logic [BAND_W-1:0] r_out_band;
    logic [PRIO_W-1:0] r_out_prio;
    logic [TIME_W-1:0] r_out_time;

    logic              w_accept, w_exec;
    logic              w_range;
    logic [BAND_W-1:0] w_band;

    t_cell_cmd         w_cmd       [NUM_BANDS];
    logic [CNT_W-1:0]  w_count     [NUM_BANDS];
    logic [PRIO_W-1:0] w_head_prio [NUM_BANDS];
    logic [TIME_W-1:0] w_head_time [NUM_BANDS];

    t_status           n_status;
    logic [PRIO_W-1:0] n_out_prio;
    logic [TIME_W-1:0] n_out_time;
    logic              w_do_ins, w_do_rem;

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_exec     = r_busy && (!r_out_valid || i_out_ready);

    // Limits are tested in order even when not ascending
    always_comb begin
        w_range = 1'b0;
        w_band  = 2'd0;
        if (i_priority_req == '0) begin
            w_range = 1'b1;
        end else if (i_priority_req <= r_top1) begin
            w_band = 2'd0;
        end else if (i_priority_req <= r_top2) begin
            w_band = 2'd1;
        end else if (i_priority_req <= r_top3) begin
            w_band = 2'd2;
        end else begin
            w_range = 1'b1;
        end
    end

    always_comb begin
        n_status   = ST_NOTHING;
        n_out_prio = '0;
        n_out_time = '0;
        w_do_ins   = 1'b0;
        w_do_rem   = 1'b0;
        if (r_range) begin
            n_status = ST_RANGE;
        end else if (!r_act) begin
            if (w_count[r_band] == CNT_W'(ENTRIES_PER_BAND)) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_INSERTED;
                w_do_ins = 1'b1;
            end
        end else if (w_count[r_band] != '0 && w_head_prio[r_band] <= r_prio) begin
            n_status   = ST_REMOVED;
            n_out_prio = w_head_prio[r_band];
            n_out_time = w_head_time[r_band];
            w_do_rem   = 1'b1;
        end
    end

    for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
        logic w_sel;
        assign w_sel = w_exec && (r_band == BAND_W'(b));

        assign w_cmd[b].ins      = w_sel && w_do_ins;
        assign w_cmd[b].rem      = w_sel && w_do_rem;
        assign w_cmd[b].prio     = r_prio;
        assign w_cmd[b].job_time = r_time;

        bsp_band u_band (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd[b]),
            .o_count     (w_count[b]),
            .o_head_prio (w_head_prio[b]),
            .o_head_time (w_head_time[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top1 <= BAND_ONE_TOP_RST;
            r_top2 <= BAND_TWO_TOP_RST;
            r_top3 <= BAND_THREE_TOP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BAND_ONE_TOP:   r_top1 <= i_cfg_data;
                CFG_BAND_TWO_TOP:   r_top2 <= i_cfg_data;
                CFG_BAND_THREE_TOP: r_top3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= i_action;
            r_range <= w_range;
            r_band  <= w_band;
            r_prio  <= i_priority_req;
            r_time  <= i_job_time;
        end
        if (w_exec) begin
            r_status   <= n_status;
            r_out_band <= r_band;
            r_out_prio <= n_out_prio;
            r_out_time <= n_out_time;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_band         = r_out_band;
    assign o_out_priority = r_out_prio;
    assign o_out_time     = r_out_time;

    a_exec_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> (o_out_valid && !r_busy))
        else $error("update did not load the result register");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_count[0] <= CNT_W'(ENTRIES_PER_BAND)) && (w_count[1] <= CNT_W'(ENTRIES_PER_BAND))
        && (w_count[2] <= CNT_W'(ENTRIES_PER_BAND)))
        else $error("band count beyond capacity");

    a_removed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_REMOVED) |-> (o_out_priority != '0))
        else $error("removed job with priority zero");

    a_no_change_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_exec |=> ($stable(w_count[0]) && $stable(w_count[1]) && $stable(w_count[2])))
        else $error("band count moved without an update");

endmodule

### rtl/bsp_cell.sv
// ----------------------------------------------------------------------------
// bsp_cell
// One slot of a sorted band: holds a job and shifts with its neighbors.
// ----------------------------------------------------------------------------
module bsp_cell (
    input  logic                      i_clk,
    input  bsp_pkg::t_cell_cmd        i_cmd,
    input  logic                      i_occupied,
    input  logic                      i_left_keep,
    input  logic [bsp_pkg::PRIO_W-1:0] i_left_prio,
    input  logic [bsp_pkg::TIME_W-1:0] i_left_time,
    input  logic [bsp_pkg::PRIO_W-1:0] i_right_prio,
    input  logic [bsp_pkg::TIME_W-1:0] i_right_time,
    output logic                      o_keep,
    output logic [bsp_pkg::PRIO_W-1:0] o_prio,
    output logic [bsp_pkg::TIME_W-1:0] o_time
);
    import bsp_pkg::*;

    logic [PRIO_W-1:0] r_prio, n_prio;
    logic [TIME_W-1:0] r_time, n_time;

    // Entries at or below the new priority stay; equal ones stay ahead of it
    assign o_keep = i_occupied && (r_prio <= i_cmd.prio);

    always_comb begin
        n_prio = r_prio;
        n_time = r_time;
        if (i_cmd.ins && !o_keep) begin
            if (i_left_keep) begin
                n_prio = i_cmd.prio;
                n_time = i_cmd.job_time;
            end else begin
                n_prio = i_left_prio;
                n_time = i_left_time;
            end
        end else if (i_cmd.rem) begin
            n_prio = i_right_prio;
            n_time = i_right_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_time <= n_time;
    end

    assign o_prio = r_prio;
    assign o_time = r_time;

endmodule

### rtl/bsp_band.sv
// ----------------------------------------------------------------------------
// bsp_band
// One band: a row of cells kept in ascending priority order, plus its count.
// ----------------------------------------------------------------------------
module bsp_band (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bsp_pkg::t_cell_cmd         i_cmd,
    output logic [bsp_pkg::CNT_W-1:0]  o_count,
    output logic [bsp_pkg::PRIO_W-1:0] o_head_prio,
    output logic [bsp_pkg::TIME_W-1:0] o_head_time
);
    import bsp_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic              w_keep [ENTRIES_PER_BAND];
    logic [PRIO_W-1:0] w_prio [ENTRIES_PER_BAND];
    logic [TIME_W-1:0] w_time [ENTRIES_PER_BAND];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.rem) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < ENTRIES_PER_BAND; i++) begin : g_cell
        logic              w_left_keep;
        logic [PRIO_W-1:0] w_left_prio, w_right_prio;
        logic [TIME_W-1:0] w_left_time, w_right_time;

        if (i == 0) begin : g_first
            assign w_left_keep = 1'b1;
            assign w_left_prio = '0;
            assign w_left_time = '0;
        end else begin : g_mid
            assign w_left_keep = w_keep[i-1];
            assign w_left_prio = w_prio[i-1];
            assign w_left_time = w_time[i-1];
        end

        if (i == ENTRIES_PER_BAND - 1) begin : g_last
            assign w_right_prio = '0;
            assign w_right_time = '0;
        end else begin : g_inner
            assign w_right_prio = w_prio[i+1];
            assign w_right_time = w_time[i+1];
        end

        bsp_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (i_cmd),
            .i_occupied   (CNT_W'(i) < r_count),
            .i_left_keep  (w_left_keep),
            .i_left_prio  (w_left_prio),
            .i_left_time  (w_left_time),
            .i_right_prio (w_right_prio),
            .i_right_time (w_right_time),
            .o_keep       (w_keep[i]),
            .o_prio       (w_prio[i]),
            .o_time       (w_time[i])
        );
    end

    assign o_count     = r_count;
    assign o_head_prio = w_prio[0];
    assign o_head_time = w_time[0];

endmodule
